>>> rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

  localparam int HueW  = 9;
  localparam int ChanW = 8;

  // Degrees per sector and the sector number width (hue/60 reaches 8)
  localparam int SectorSpan = 60;
  localparam int SectorW    = 4;
  localparam int PosW       = 6;
  localparam int FracW      = 7;

  // hue / 60 as (hue * 1093) >> 16, exact for every 9-bit hue
  localparam int HueRecip      = 1093;
  localparam int HueRecipW     = 11;
  localparam int HueRecipShift = 16;

  // x / 60 as (x * 17477) >> 20, exact for x up to 255 * 60
  localparam int DivRecip      = 17477;
  localparam int DivRecipW     = 15;
  localparam int DivRecipShift = 20;

  localparam int UpProdW   = ChanW + PosW;
  localparam int DownProdW = ChanW + FracW;
  localparam int QuotProdW = DownProdW + DivRecipW;

  // Sector codes
  localparam logic [SectorW-1:0] SEC_RED_GREEN_UP  = 4'd0;
  localparam logic [SectorW-1:0] SEC_RED_DOWN      = 4'd1;
  localparam logic [SectorW-1:0] SEC_BLUE_UP       = 4'd2;
  localparam logic [SectorW-1:0] SEC_GREEN_DOWN    = 4'd3;
  localparam logic [SectorW-1:0] SEC_RED_UP        = 4'd4;

  typedef logic [ChanW-1:0] chan_t;

endpackage

>>> rtl/hsv_to_rgb_converter.sv
// Channel   Direction  Ports                         Transfer
// -------   ---------  ----------------------------  ------------------------------
// pixel in  input      hue, saturation, brightness   edge with start high, busy low
// pixel out output     red, green, blue              edge that ends the done cycle
//
// Cycles: a pixel enters every clock; its RGB result shows on done once it has
// passed the five register stages: sector split and base product, remainder and
// span, ramp products, divide-by-60 product, final mix.
// Reset: rst clears the stage valid bits only; data registers carry no reset.
// Stalls: none; busy stays low and the receiver takes every result as shown.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [HueW-1:0]  hue,
  input  logic [ChanW-1:0] saturation,
  input  logic [ChanW-1:0] brightness,
  output logic             done,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  // Stage valid bits travel alongside the data
  logic [4:0] valid;

  // Stage 1: sector estimate and floor product
  logic [HueW+HueRecipW-1:0] sec_prod;
  logic [2*ChanW-1:0]        base_prod;
  logic [HueW-1:0]           s1_hue;
  logic [SectorW-1:0]        s1_sector;
  chan_t                     s1_base;
  chan_t                     s1_val;
  logic                      s1_grey;

  // Stage 2: position inside the sector and ramp span
  logic [HueW-1:0]           sector_start;
  logic [HueW-1:0]           hue_rem;
  logic [PosW-1:0]           s2_pos;
  chan_t                     s2_span;
  logic [SectorW-1:0]        s2_sector;
  chan_t                     s2_base;
  chan_t                     s2_val;
  logic                      s2_grey;

  // Stage 3: rising and falling ramp products
  logic [FracW-1:0]          frac_down;
  logic [UpProdW-1:0]        s3_up_prod;
  logic [DownProdW-1:0]      s3_down_prod;
  logic [SectorW-1:0]        s3_sector;
  chan_t                     s3_base;
  chan_t                     s3_val;
  logic                      s3_grey;

  // Stage 4: divide by the sector span through a reciprocal
  logic [QuotProdW-1:0]      s4_up_quot;
  logic [QuotProdW-1:0]      s4_down_quot;
  logic [SectorW-1:0]        s4_sector;
  chan_t                     s4_base;
  chan_t                     s4_val;
  logic                      s4_grey;

  // Stage 5: ramp levels and channel selection
  chan_t                     up_lvl;
  chan_t                     down_lvl;
  chan_t                     red_next;
  chan_t                     green_next;
  chan_t                     blue_next;

  assign busy = 1'b0;
  assign done = valid[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], start & ~busy};
    end
  end

  // Stage 1
  assign sec_prod  = HueW'(hue) * HueRecipW'(HueRecip);
  assign base_prod = (ChanW'(255) - saturation) * brightness;

  always_ff @(posedge clk) begin
    s1_hue    <= hue;
    s1_sector <= sec_prod[HueRecipShift +: SectorW];
    s1_base   <= base_prod[2*ChanW-1:ChanW];
    s1_val    <= brightness;
    s1_grey   <= (saturation == '0);
  end

  // Stage 2: remainder hue - 60 * sector, always below 60
  assign sector_start = HueW'(s1_sector) * HueW'(SectorSpan);
  assign hue_rem      = s1_hue - sector_start;

  always_ff @(posedge clk) begin
    s2_pos    <= hue_rem[PosW-1:0];
    s2_span   <= s1_val - s1_base;
    s2_sector <= s1_sector;
    s2_base   <= s1_base;
    s2_val    <= s1_val;
    s2_grey   <= s1_grey;
  end

  // Stage 3
  assign frac_down = FracW'(SectorSpan) - FracW'(s2_pos);

  always_ff @(posedge clk) begin
    s3_up_prod   <= s2_span * UpProdW'(s2_pos);
    s3_down_prod <= DownProdW'(s2_span) * DownProdW'(frac_down);
    s3_sector    <= s2_sector;
    s3_base      <= s2_base;
    s3_val       <= s2_val;
    s3_grey      <= s2_grey;
  end

  // Stage 4
  always_ff @(posedge clk) begin
    s4_up_quot   <= QuotProdW'(s3_up_prod) * QuotProdW'(DivRecip);
    s4_down_quot <= QuotProdW'(s3_down_prod) * QuotProdW'(DivRecip);
    s4_sector    <= s3_sector;
    s4_base      <= s3_base;
    s4_val       <= s3_val;
    s4_grey      <= s3_grey;
  end

  // Stage 5: the ramp never passes brightness, so eight bits hold the sum
  assign up_lvl   = s4_up_quot[DivRecipShift +: ChanW] + s4_base;
  assign down_lvl = s4_down_quot[DivRecipShift +: ChanW] + s4_base;

  always_comb begin
    red_next   = s4_val;
    green_next = s4_base;
    blue_next  = down_lvl;
    if (s4_grey) begin
      red_next   = s4_val;
      green_next = s4_val;
      blue_next  = s4_val;
    end else begin
      case (s4_sector)
        SEC_RED_GREEN_UP: begin
          red_next   = s4_val;
          green_next = up_lvl;
          blue_next  = s4_base;
        end
        SEC_RED_DOWN: begin
          red_next   = down_lvl;
          green_next = s4_val;
          blue_next  = s4_base;
        end
        SEC_BLUE_UP: begin
          red_next   = s4_base;
          green_next = s4_val;
          blue_next  = up_lvl;
        end
        SEC_GREEN_DOWN: begin
          red_next   = s4_base;
          green_next = down_lvl;
          blue_next  = s4_val;
        end
        SEC_RED_UP: begin
          red_next   = up_lvl;
          green_next = s4_base;
          blue_next  = s4_val;
        end
        default: begin
          // last sector, also taken by hue codes past 359
          red_next   = s4_val;
          green_next = s4_base;
          blue_next  = down_lvl;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

`ifndef SYNTH
  // Every accepted pixel comes out as a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted pixel did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without an accepted pixel");

  // One channel always sits at the brightness of the pixel
  a_peak: assert property (@(posedge clk) disable iff (rst)
    done |-> (red == $past(brightness, 5) || green == $past(brightness, 5) ||
              blue == $past(brightness, 5)))
    else $error("no channel equals brightness");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && $past(saturation, 5) == '0) |-> (red == green && green == blue))
    else $error("grey pixel has unequal channels");
`endif

endmodule

>>> tb/hsv_to_rgb_converter_tb.sv
module hsv_to_rgb_converter_tb;
  import hsvrgb_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int ResetCycles = 7;
  localparam int ChanMax     = 255;
  // Five register stages in the pipeline; allow a few extra cycles of margin
  localparam int PipeDepth   = 5;
  localparam int DrainLimit  = 200;
  localparam int PhaseItems  = 150;
  localparam int NumDirected = 24;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_pixel_t;

  // One row of the directed table: the HSV pixel, and a hand-typed RGB result
  // where it is obvious; rows with typed clear fall back to the predictor.
  typedef struct packed {
    logic [HueW-1:0] hue;
    chan_t           sat;
    chan_t           val;
    logic            typed;
    rgb_pixel_t      rgb;
  } pixel_case_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [HueW-1:0]  hue = '0;
  logic [ChanW-1:0] saturation = '0;
  logic [ChanW-1:0] brightness = '0;
  logic             done;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  // RGB pixels still owed by the pipeline, oldest first
  rgb_pixel_t rgb_pending[$];

  int err_cnt     = 0;
  int pixels_sent = 0;
  int pixels_seen = 0;
  int grey_cnt    = 0;
  int wrap_cnt    = 0;
  int gap_pct     = 0;

  pixel_case_t directed_cases [NumDirected] = '{
    // Grey pixels: all channels follow brightness, hue is ignored
    '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd511, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd200, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
    // Zero brightness forces black regardless of hue and saturation
    '{9'd100, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    // Full saturation and brightness at each sector start: pure primaries and
    // secondaries, with the falling channel still at full level
    '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    // Mid-sector ramps, one per sector
    '{9'd30,  8'd200, 8'd180, 1'b0, '0},
    '{9'd90,  8'd200, 8'd180, 1'b0, '0},
    '{9'd150, 8'd200, 8'd180, 1'b0, '0},
    '{9'd210, 8'd200, 8'd180, 1'b0, '0},
    '{9'd270, 8'd200, 8'd180, 1'b0, '0},
    '{9'd330, 8'd200, 8'd180, 1'b0, '0},
    // Top of the nominal range, codes past 359 (last sector), then hue 256
    '{9'd359, 8'd255, 8'd255, 1'b0, '0},
    '{9'd360, 8'd128, 8'd200, 1'b0, '0},
    '{9'd419, 8'd1,   8'd255, 1'b0, '0},
    '{9'd420, 8'd255, 8'd1,   1'b0, '0},
    '{9'd479, 8'd170, 8'd85,  1'b0, '0},
    '{9'd480, 8'd85,  8'd170, 1'b0, '0},
    '{9'd511, 8'd255, 8'd255, 1'b0, '0},
    '{9'd256, 8'd1,   8'd1,   1'b0, '0}
  };

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Integer HSV to RGB conversion. Saturation zero gives grey; otherwise form
  // the floor level and ramp one channel between floor and brightness inside
  // the 60-degree sector. Sectors six and up (hue 360..511) share the last
  // sector's rule.
  function automatic rgb_pixel_t convert_pixel(logic [HueW-1:0] h, chan_t s, chan_t v);
    rgb_pixel_t       px;
    int unsigned      floor_lvl;
    int unsigned      pos;
    int unsigned      rise;
    int unsigned      fall;
    logic [SectorW-1:0] sector;
    if (s == '0) begin
      px = '{v, v, v};
    end else begin
      floor_lvl = ((ChanMax - s) * v) >> 8;
      pos       = h % SectorSpan;
      rise      = ((v - floor_lvl) * pos) / SectorSpan + floor_lvl;
      fall      = ((v - floor_lvl) * (SectorSpan - pos)) / SectorSpan + floor_lvl;
      sector    = SectorW'(h / SectorSpan);
      case (sector)
        SEC_RED_GREEN_UP: px = '{v, chan_t'(rise), chan_t'(floor_lvl)};
        SEC_RED_DOWN:     px = '{chan_t'(fall), v, chan_t'(floor_lvl)};
        SEC_BLUE_UP:      px = '{chan_t'(floor_lvl), v, chan_t'(rise)};
        SEC_GREEN_DOWN:   px = '{chan_t'(floor_lvl), chan_t'(fall), v};
        SEC_RED_UP:       px = '{chan_t'(rise), chan_t'(floor_lvl), v};
        default:          px = '{v, chan_t'(floor_lvl), chan_t'(fall)};
      endcase
    end
    return px;
  endfunction

  // Present one pixel and hold it until the transfer. The owed result is
  // queued up front: results come back in order and never before the
  // transfer, so queuing early cannot race the checker.
  task automatic send_pixel(logic [HueW-1:0] h, chan_t s, chan_t v, rgb_pixel_t rgb);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    rgb_pending.push_back(rgb);
    start      <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    pixels_sent++;
    if (s == '0) grey_cnt++;
    if (h >= 360) wrap_cnt++;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Draw a random pixel. Bias toward grey, black, full brightness and sector
  // boundaries, but keep the bulk uniform so every input bit toggles.
  task automatic send_random_pixel();
    logic [HueW-1:0] h;
    chan_t           s;
    chan_t           v;
    if ($urandom_range(0, 7) == 0) h = HueW'(SectorSpan * $urandom_range(0, 8));
    else h = HueW'($urandom_range(0, 511));
    if ($urandom_range(0, 7) == 0) s = '0;
    else s = chan_t'($urandom_range(0, ChanMax));
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = chan_t'(ChanMax);
      default: v = chan_t'($urandom_range(0, ChanMax));
    endcase
    send_pixel(h, s, v, convert_pixel(h, s, v));
  endtask

  task automatic check_chan(string name, chan_t exp_val, chan_t act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // Result checker: every done cycle is one transfer; match it against the
  // oldest owed pixel, field by field.
  always @(posedge clk) begin
    rgb_pixel_t owed;
    if (!rst) begin
      if ($isunknown(done)) begin
        $error("done is unknown after reset");
        err_cnt++;
      end else if (done) begin
        if (rgb_pending.size() == 0) begin
          $error("result with no pixel outstanding: r=%0d g=%0d b=%0d", red, green, blue);
          err_cnt++;
        end else begin
          owed = rgb_pending.pop_front();
          check_chan("red", owed.red, red);
          check_chan("green", owed.green, green);
          check_chan("blue", owed.blue, blue);
          pixels_seen++;
        end
      end
    end
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #(ClkPeriod * 200000);
    $display("FAIL hsv_to_rgb_converter");
    $finish;
  end

  initial begin
    int waited;
    pixel_case_t row;

    // Hold reset for a few cycles, then release it synchronously
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table back to back
    gap_pct = 0;
    for (int i = 0; i < NumDirected; i++) begin
      row = directed_cases[i];
      send_pixel(row.hue, row.sat, row.val,
                 row.typed ? row.rgb : convert_pixel(row.hue, row.sat, row.val));
    end

    // Random phase one: light sender gaps
    gap_pct = 27;
    repeat (PhaseItems) send_random_pixel();

    // Drop start and let the pipeline empty completely before going on
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (rgb_pending.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end

    // Random phase two: heavy sender gaps
    gap_pct = 71;
    repeat (PhaseItems) send_random_pixel();

    // Random phase three: full rate, one pixel per clock
    gap_pct = 0;
    repeat (PhaseItems) send_random_pixel();

    // Drain: wait for the owed results, then a few more cycles for strays
    start <= 1'b0;
    waited = 0;
    while (rgb_pending.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (rgb_pending.size() != 0) begin
      $error("%0d results never arrived", rgb_pending.size());
      err_cnt++;
    end
    repeat (PipeDepth + 3) @(posedge clk);

    $display("Converted %0d pixels, %0d results checked (%0d grey, %0d hue past 359)",
             pixels_sent, pixels_seen, grey_cnt, wrap_cnt);
    $display("Gap rates 0, 27 and 71 percent with one full drain between phases");
    if (err_cnt == 0) begin
      $display("PASS hsv_to_rgb_converter");
    end else begin
      $display("FAIL hsv_to_rgb_converter");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_tb.sv
